FILE: src/cit_pkg.sv
// shared widths, types and codes for the chunk index table
package cit_pkg;

   localparam int TOTAL_W  = 40;
   localparam int OFFSET_W = 32;
   localparam int COUNT_W  = 32;
   localparam int KIND_W   = 3;
   localparam int CHUNKS_W = 32;
   localparam int ELEMS_W  = 48;
   localparam int POS_W    = 4;

   typedef logic [TOTAL_W-1:0]  total_type;
   typedef logic [OFFSET_W-1:0] offset_type;
   typedef logic [COUNT_W-1:0]  count_type;
   typedef logic [KIND_W-1:0]   kind_type;
   typedef logic [CHUNKS_W-1:0] chunks_type;
   typedef logic [ELEMS_W-1:0]  elems_type;
   typedef logic [POS_W-1:0]    pos_type;

   localparam total_type TOTAL_MAX = {TOTAL_W{1'b1}};

   localparam logic OP_APPEND = 1'b0;
   localparam logic OP_FIND   = 1'b1;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic       find;
      logic       load;
      logic       shift;
      total_type  total;
      offset_type offset;
      total_type  oid;
   } cell_cmd_type;

   // scan token handed from cell to cell; best is the running minimum gap
   // on a compaction scan and the found offset on a find
   typedef struct packed {
      logic       hit;
      offset_type best;
   } token_type;

   typedef struct packed {
      pos_type    entry_count;
      logic       dropped_valid;
      pos_type    dropped_entry;
      chunks_type kind_chunks;
      elems_type  kind_elements;
      pos_type    found_entry;
      offset_type found_offset;
      logic       find_error;
   } rsp_payload_type;

endpackage

FILE: src/cit_channels.sv
// request and response channel interfaces of the chunk index table
interface cit_req_if;
   logic                  valid;
   logic                  ready;
   logic                  op;
   cit_pkg::count_type    chunk_count;
   cit_pkg::offset_type   chunk_offset;
   cit_pkg::kind_type     chunk_kind;
   cit_pkg::total_type    oid_value;

   modport source (output valid, op, chunk_count, chunk_offset, chunk_kind, oid_value,
                   input ready);
   modport sink   (input valid, op, chunk_count, chunk_offset, chunk_kind, oid_value,
                   output ready);
endinterface

interface cit_rsp_if;
   logic                  valid;
   logic                  ready;
   cit_pkg::pos_type      entry_count;
   logic                  dropped_valid;
   cit_pkg::pos_type      dropped_entry;
   cit_pkg::chunks_type   kind_chunks;
   cit_pkg::elems_type    kind_elements;
   cit_pkg::pos_type      found_entry;
   cit_pkg::offset_type   found_offset;
   logic                  find_error;

   modport source (output valid, entry_count, dropped_valid, dropped_entry, kind_chunks,
                          kind_elements, found_entry, found_offset, find_error,
                   input ready);
   modport sink   (input valid, entry_count, dropped_valid, dropped_entry, kind_chunks,
                         kind_elements, found_entry, found_offset, find_error,
                   output ready);
endinterface

FILE: src/cit_cell.sv
// one table entry of the chain plus its stage of the scan token
module cit_cell #(
   parameter int IDX_W = 4
) (
   input  logic                 clock,
   input  cit_pkg::cell_cmd_type cmd,
   input  logic [IDX_W-1:0]     cell_id,
   input  logic [IDX_W-1:0]     sel_idx,
   input  logic [IDX_W-1:0]     used,
   input  cit_pkg::offset_type  prev_offset,
   input  cit_pkg::total_type   next_total,
   input  cit_pkg::offset_type  next_offset,
   input  cit_pkg::token_type   tok_prev,
   input  logic [IDX_W-1:0]     tok_idx_prev,
   output cit_pkg::total_type   total,
   output cit_pkg::offset_type  offset,
   output cit_pkg::token_type   tok,
   output logic [IDX_W-1:0]     tok_idx
);
   import cit_pkg::*;

   total_type         total_ff, total_in;
   offset_type        offset_ff, offset_in;
   token_type         tok_ff, tok_in;
   logic [IDX_W-1:0]  tok_idx_ff, tok_idx_in;
   logic              not_head;
   logic              gap_ok;
   offset_type        gap;

   always_comb begin
      not_head   = (cell_id != '0);
      gap_ok     = (offset_ff >= prev_offset);
      gap        = offset_ff - prev_offset;
      total_in   = total_ff;
      offset_in  = offset_ff;
      tok_in     = tok_prev;
      tok_idx_in = tok_idx_prev;

      if (cmd.load && (cell_id == sel_idx)) begin
         total_in  = cmd.total;
         offset_in = cmd.offset;
      end else if (cmd.shift && (cell_id >= sel_idx)) begin
         total_in  = next_total;
         offset_in = next_offset;
      end

      if (cmd.find) begin
         // first entry whose successor total passes the oid
         if (not_head && (cell_id < used) && !tok_prev.hit && (total_ff > cmd.oid)) begin
            tok_in.hit  = 1'b1;
            tok_idx_in  = cell_id - IDX_W'(1);
            tok_in.best = (cell_id == IDX_W'(1)) ? '0 : prev_offset;
         end
      end else begin
         // a falling offset never wins
         if (not_head && gap_ok && (gap < tok_prev.best)) begin
            tok_in.best = gap;
            tok_idx_in  = cell_id;
         end
      end
   end

   always_ff @(posedge clock) begin
      total_ff   <= total_in;
      offset_ff  <= offset_in;
      tok_ff     <= tok_in;
      tok_idx_ff <= tok_idx_in;
   end

   assign total   = total_ff;
   assign offset  = offset_ff;
   assign tok     = tok_ff;
   assign tok_idx = tok_idx_ff;

endmodule

FILE: src/cit_kind_counters.sv
// per-kind chunk and element counters
module cit_kind_counters #(
   parameter int KIND_COUNT = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                upd,
   input  cit_pkg::kind_type   kind,
   input  cit_pkg::count_type  count,
   output cit_pkg::chunks_type kind_chunks,
   output cit_pkg::elems_type  kind_elems
);
   import cit_pkg::*;

   localparam int KW = (KIND_COUNT > 1) ? $clog2(KIND_COUNT) : 1;
   localparam logic [KIND_W+1:0] KIND_LIMIT = (KIND_W+2)'(KIND_COUNT);

   chunks_type        chunks_ff [KIND_COUNT];
   elems_type         elems_ff [KIND_COUNT];
   chunks_type        chunks_in;
   elems_type         elems_in;
   logic [KW-1:0]     sel;
   logic              in_range;

   always_comb begin
      in_range  = ((KIND_W+2)'(kind) < KIND_LIMIT);
      sel       = KW'(kind);
      chunks_in = chunks_ff[sel] + CHUNKS_W'(1);
      elems_in  = elems_ff[sel] + ELEMS_W'(count);
   end

   assign kind_chunks = in_range ? chunks_in : '0;
   assign kind_elems  = in_range ? elems_in : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < KIND_COUNT; k++) begin
            chunks_ff[k] <= '0;
            elems_ff[k]  <= '0;
         end
      end else if (upd && in_range) begin
         chunks_ff[sel] <= chunks_in;
         elems_ff[sel]  <= elems_in;
      end
   end

endmodule

FILE: src/chunk_index_table_unit.sv
// top level of the chunk index table: control, cell chain and kind counters
// an append with room goes from IDLE to DONE, which waits for a free response register;
//   a find or an append to a full table passes through SCAN first, where the scan token
//   walks one cell a cycle; requests are taken only in IDLE, one item at a time
// reset: synchronous, clears entry count, kind counters and handshake state;
//   entry contents are undefined until written and get no clearing pass
module chunk_index_table_unit #(
   parameter int INDEX_SLOTS = 16,
   parameter int KIND_COUNT  = 8
) (
   input logic       clock,
   input logic       reset,
   cit_req_if.sink   req_bus,
   cit_rsp_if.source rsp_bus
);
   import cit_pkg::*;

   localparam int IDX_W = $clog2(INDEX_SLOTS);
   localparam int CNT_W = $clog2(INDEX_SLOTS + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(INDEX_SLOTS - 1);
   localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(INDEX_SLOTS);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [IDX_W-1:0]  used_ff, used_in;
   logic              rsp_valid_ff, rsp_valid_in;
   total_type         last_total_ff, last_total_in;
   offset_type        last_offset_ff, last_offset_in;
   logic              op_ff, op_in;
   total_type         oid_ff, oid_in;
   logic              err_ff, err_in;
   rsp_payload_type   res_ff, res_in;
   rsp_payload_type   out_ff, out_in;

   logic              req_acc;
   logic              out_free;
   total_type         base_total;
   logic [TOTAL_W:0]  total_sum;
   total_type         new_total;
   cell_cmd_type      cell_cmd;
   logic [IDX_W-1:0]  sel_idx;
   token_type         launch_tok;
   token_type         last_tok;
   logic [IDX_W-1:0]  last_idx;
   chunks_type        kind_chunks;
   elems_type         kind_elems;

   total_type         cell_total [INDEX_SLOTS];
   offset_type        cell_offset [INDEX_SLOTS];
   token_type         cell_tok [INDEX_SLOTS];
   logic [IDX_W-1:0]  cell_tok_idx [INDEX_SLOTS];

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_acc       = req_bus.valid && req_bus.ready;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;

   assign base_total = (used_ff == '0) ? '0 : last_total_ff;
   assign total_sum  = {1'b0, base_total} + (TOTAL_W+1)'(req_bus.chunk_count);
   assign new_total  = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];

   assign last_tok = cell_tok[INDEX_SLOTS-1];
   assign last_idx = cell_tok_idx[INDEX_SLOTS-1];

   // compaction starts with entry 0 and offset of entry 1 as the minimum
   always_comb begin
      launch_tok.hit  = 1'b0;
      launch_tok.best = (op_ff == OP_FIND) ? '0 : cell_offset[1];
   end

   cit_kind_counters #(
      .KIND_COUNT (KIND_COUNT)
   ) u_kinds (
      .clock       (clock),
      .reset       (reset),
      .upd         (req_acc && (req_bus.op == OP_APPEND)),
      .kind        (req_bus.chunk_kind),
      .count       (req_bus.chunk_count),
      .kind_chunks (kind_chunks),
      .kind_elems  (kind_elems)
   );

   for (genvar k = 0; k < INDEX_SLOTS; k++) begin : g_cell
      token_type         tok_src;
      logic [IDX_W-1:0]  tok_idx_src;
      offset_type        prev_off;
      total_type         nxt_total;
      offset_type        nxt_off;

      if (k == 0) begin : g_head
         assign tok_src     = launch_tok;
         assign tok_idx_src = '0;
         assign prev_off    = '0;
      end else begin : g_body
         assign tok_src     = cell_tok[k-1];
         assign tok_idx_src = cell_tok_idx[k-1];
         assign prev_off    = cell_offset[k-1];
      end

      // the end slot shifts onto itself
      if (k == INDEX_SLOTS - 1) begin : g_tail
         assign nxt_total = cell_total[k];
         assign nxt_off   = cell_offset[k];
      end else begin : g_link
         assign nxt_total = cell_total[k+1];
         assign nxt_off   = cell_offset[k+1];
      end

      cit_cell #(
         .IDX_W (IDX_W)
      ) u_cell (
         .clock        (clock),
         .cmd          (cell_cmd),
         .cell_id      (IDX_W'(k)),
         .sel_idx      (sel_idx),
         .used         (used_ff),
         .prev_offset  (prev_off),
         .next_total   (nxt_total),
         .next_offset  (nxt_off),
         .tok_prev     (tok_src),
         .tok_idx_prev (tok_idx_src),
         .total        (cell_total[k]),
         .offset       (cell_offset[k]),
         .tok          (cell_tok[k]),
         .tok_idx      (cell_tok_idx[k])
      );
   end

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      used_in        = used_ff;
      last_total_in  = last_total_ff;
      last_offset_in = last_offset_ff;
      op_in          = op_ff;
      oid_in         = oid_ff;
      err_in         = err_ff;
      res_in         = res_ff;
      out_in         = out_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;

      cell_cmd.find   = (op_ff == OP_FIND);
      cell_cmd.load   = 1'b0;
      cell_cmd.shift  = 1'b0;
      cell_cmd.total  = new_total;
      cell_cmd.offset = req_bus.chunk_offset;
      cell_cmd.oid    = oid_ff;
      sel_idx         = used_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               op_in  = req_bus.op;
               oid_in = req_bus.oid_value;
               cnt_in = '0;
               res_in = '0;
               if (req_bus.op == OP_APPEND) begin
                  // a full table writes the end slot, which is used_ff itself
                  cell_cmd.load        = 1'b1;
                  res_in.kind_chunks   = kind_chunks;
                  res_in.kind_elements = kind_elems;
                  if (used_ff == LAST_IDX) begin
                     state_in = ST_SCAN;
                  end else begin
                     used_in        = used_ff + IDX_W'(1);
                     last_total_in  = new_total;
                     last_offset_in = req_bus.chunk_offset;
                     state_in       = ST_DONE;
                  end
               end else begin
                  err_in   = (used_ff == '0) || (req_bus.oid_value > last_total_ff);
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == SCAN_END) begin
               state_in = ST_DONE;
               if (op_ff == OP_FIND) begin
                  if (err_ff) begin
                     res_in.find_error = 1'b1;
                  end else if (last_tok.hit) begin
                     res_in.found_entry  = POS_W'(last_idx);
                     res_in.found_offset = last_tok.best;
                  end else begin
                     res_in.found_entry  = POS_W'(used_ff - IDX_W'(1));
                     res_in.found_offset = (used_ff == IDX_W'(1)) ? '0 : last_offset_ff;
                  end
               end else begin
                  cell_cmd.shift       = 1'b1;
                  sel_idx              = last_idx;
                  res_in.dropped_valid = 1'b1;
                  res_in.dropped_entry = POS_W'(last_idx);
                  // new entry survives unless it was the one removed
                  if (last_idx != LAST_IDX) begin
                     last_total_in  = cell_total[INDEX_SLOTS-1];
                     last_offset_in = cell_offset[INDEX_SLOTS-1];
                  end
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_in             = res_ff;
               out_in.entry_count = POS_W'(used_ff);
               rsp_valid_in       = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_total_ff  <= last_total_in;
      last_offset_ff <= last_offset_in;
      op_ff          <= op_in;
      oid_ff         <= oid_in;
      err_ff         <= err_in;
      res_ff         <= res_in;
      out_ff         <= out_in;
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.entry_count   = out_ff.entry_count;
   assign rsp_bus.dropped_valid = out_ff.dropped_valid;
   assign rsp_bus.dropped_entry = out_ff.dropped_entry;
   assign rsp_bus.kind_chunks   = out_ff.kind_chunks;
   assign rsp_bus.kind_elements = out_ff.kind_elements;
   assign rsp_bus.found_entry   = out_ff.found_entry;
   assign rsp_bus.found_offset  = out_ff.found_offset;
   assign rsp_bus.find_error    = out_ff.find_error;

`ifndef SYNTHESIS
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= LAST_IDX)
      else $error("entry count beyond the end slot");

   a_scan_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (cnt_ff <= SCAN_END))
      else $error("scan ran past the chain");

   a_full_scan: assert property (@(posedge clock) disable iff (reset)
      (req_acc && (req_bus.op == OP_APPEND) && (used_ff == LAST_IDX))
      |=> ((state_ff == ST_SCAN) && (cnt_ff == '0) && (used_ff == LAST_IDX)))
      else $error("full append did not start compaction");

   a_err_find: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DONE) && res_ff.find_error)
      |-> ((op_ff == OP_FIND) && !res_ff.dropped_valid))
      else $error("find error on a non-find beat");
`endif

endmodule

FILE: verif/tb.sv
// self-checking testbench of the chunk index table: directed table, then random appends and finds
module tb;
   import cit_pkg::*;

   localparam int SLOTS = 16;
   localparam int KINDS = 8;

   typedef struct packed {
      logic       op;
      count_type  count;
      offset_type offset;
      kind_type   kind;
      total_type  oid;
   } chunk_req_type;

   typedef struct {
      chunk_req_type   item;
      bit              typed;
      rsp_payload_type want;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cit_req_if req_bus();
   cit_rsp_if rsp_bus();

   chunk_index_table_unit #(
      .INDEX_SLOTS(SLOTS),
      .KIND_COUNT (KINDS)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow copy of the table and the per-kind counters
   total_type   shadow_totals[SLOTS];
   offset_type  shadow_offsets[SLOTS];
   int unsigned shadow_used = 0;
   chunks_type  shadow_chunks[KINDS] = '{default: '0};
   elems_type   shadow_elems[KINDS] = '{default: '0};

   rsp_payload_type pending_rsp[$];
   dir_row_type     dir_rows[$];
   int              fail_count = 0;
   int              send_idle_pct = 0;
   int              stall_pct = 0;
   offset_type      last_offset = '0;

   function automatic total_type sat_total(input total_type base, input count_type add);
      logic [TOTAL_W:0] sum;
      sum = {1'b0, base} + (TOTAL_W + 1)'(add);
      return (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[TOTAL_W-1:0];
   endfunction

   // applies one beat to the shadow table and returns the response it must cause
   function automatic rsp_payload_type apply_to_shadow(input chunk_req_type it);
      rsp_payload_type r;
      int unsigned     top;
      int unsigned     j;
      int unsigned     i;
      logic [63:0]     min_gap;
      logic [63:0]     gap;
      r = '0;
      top = shadow_used;
      if (it.op == OP_APPEND) begin
         if (int'(it.kind) < KINDS) begin
            shadow_chunks[it.kind] = shadow_chunks[it.kind] + CHUNKS_W'(1);
            shadow_elems[it.kind] = shadow_elems[it.kind] + ELEMS_W'(it.count);
            r.kind_chunks = shadow_chunks[it.kind];
            r.kind_elements = shadow_elems[it.kind];
         end
         if (top < SLOTS - 1) begin
            shadow_totals[top] = sat_total((top != 0) ? shadow_totals[top-1] : '0, it.count);
            shadow_offsets[top] = it.offset;
            shadow_used = top + 1;
         end else begin
            top = SLOTS - 1;
            shadow_totals[top] = sat_total(shadow_totals[top-1], it.count);
            shadow_offsets[top] = it.offset;
            // gap is unsigned 64-bit, so a falling offset never wins
            min_gap = {32'b0, shadow_offsets[1]};
            j = 0;
            for (i = 1; i <= top; i++) begin
               gap = {32'b0, shadow_offsets[i]} - {32'b0, shadow_offsets[i-1]};
               if (gap < min_gap) begin
                  min_gap = gap;
                  j = i;
               end
            end
            for (i = j; i < top; i++) begin
               shadow_totals[i] = shadow_totals[i+1];
               shadow_offsets[i] = shadow_offsets[i+1];
            end
            r.dropped_valid = 1'b1;
            r.dropped_entry = pos_type'(j);
         end
      end else begin
         if (top == 0 || it.oid > shadow_totals[top-1]) begin
            r.find_error = 1'b1;
         end else begin
            i = 0;
            while (i + 1 < top && !(shadow_totals[i+1] > it.oid)) i++;
            r.found_entry = pos_type'(i);
            r.found_offset = (i != 0) ? shadow_offsets[i] : '0;
         end
      end
      r.entry_count = pos_type'(shadow_used);
      return r;
   endfunction

   function automatic rsp_payload_type mk_rsp(input pos_type ec, input logic dv,
                                              input pos_type de, input chunks_type kc,
                                              input elems_type ke, input pos_type fe,
                                              input offset_type fo, input logic err);
      rsp_payload_type r;
      r.entry_count = ec;
      r.dropped_valid = dv;
      r.dropped_entry = de;
      r.kind_chunks = kc;
      r.kind_elements = ke;
      r.found_entry = fe;
      r.found_offset = fo;
      r.find_error = err;
      return r;
   endfunction

   function automatic dir_row_type appnd(input count_type c, input offset_type o,
                                         input kind_type k);
      dir_row_type row;
      row.item = '{op: OP_APPEND, count: c, offset: o, kind: k, oid: '0};
      row.typed = 1'b0;
      row.want = '0;
      return row;
   endfunction

   function automatic dir_row_type lookup(input total_type oid);
      dir_row_type row;
      row.item = '{op: OP_FIND, count: '0, offset: '0, kind: '0, oid: oid};
      row.typed = 1'b0;
      row.want = '0;
      return row;
   endfunction

   function automatic dir_row_type with_want(input dir_row_type row, input rsp_payload_type w);
      dir_row_type r;
      r = row;
      r.typed = 1'b1;
      r.want = w;
      return r;
   endfunction

   function automatic string fmt_rsp(input rsp_payload_type r);
      return $sformatf("cnt=%0d drop=%0b@%0d kc=%0h ke=%0h found=%0d off=%0h err=%0b",
                       r.entry_count, r.dropped_valid, r.dropped_entry, r.kind_chunks,
                       r.kind_elements, r.found_entry, r.found_offset, r.find_error);
   endfunction

   function automatic count_type rand_count(input bit heavy);
      if (heavy && $urandom_range(9) != 0) return '1;
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         2, 3:    return count_type'($urandom_range(1000));
         default: return count_type'($urandom);
      endcase
   endfunction

   // mostly rising offsets with small steps so that the gaps compete
   function automatic offset_type rand_offset();
      case ($urandom_range(9))
         0:       last_offset = offset_type'($urandom);
         1:       last_offset = last_offset;
         2:       last_offset = '0;
         3:       last_offset = '1;
         default: last_offset = last_offset + offset_type'($urandom_range(5000, 1));
      endcase
      return last_offset;
   endfunction

   // oids around the stored totals, with the edges of the last one
   function automatic total_type rand_oid();
      total_type last;
      int unsigned k;
      if (shadow_used == 0) return total_type'({$urandom, $urandom});
      last = shadow_totals[shadow_used-1];
      case ($urandom_range(9))
         0:       return total_type'({$urandom, $urandom});
         1:       return '0;
         2:       return last;
         3:       return last + total_type'(1);
         4:       return TOTAL_MAX;
         default: begin
            k = $urandom_range(shadow_used - 1);
            return shadow_totals[k] + total_type'($urandom_range(2)) - total_type'(1);
         end
      endcase
   endfunction

   task automatic send_req(input chunk_req_type it, input bit typed,
                           input rsp_payload_type want);
      rsp_payload_type pred;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.op <= it.op;
      req_bus.chunk_count <= it.count;
      req_bus.chunk_offset <= it.offset;
      req_bus.chunk_kind <= it.kind;
      req_bus.oid_value <= it.oid;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      pred = apply_to_shadow(it);
      pending_rsp.push_back(typed ? want : pred);
   endtask

   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      rsp_payload_type got;
      rsp_payload_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         got = mk_rsp(rsp_bus.entry_count, rsp_bus.dropped_valid, rsp_bus.dropped_entry,
                      rsp_bus.kind_chunks, rsp_bus.kind_elements, rsp_bus.found_entry,
                      rsp_bus.found_offset, rsp_bus.find_error);
         if (pending_rsp.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) $display("unexpected response beat: %s", fmt_rsp(got));
         end else begin
            want = pending_rsp.pop_front();
            if (got.entry_count !== want.entry_count ||
                got.dropped_valid !== want.dropped_valid ||
                got.dropped_entry !== want.dropped_entry ||
                got.kind_chunks !== want.kind_chunks ||
                got.kind_elements !== want.kind_elements ||
                got.found_entry !== want.found_entry ||
                got.found_offset !== want.found_offset ||
                got.find_error !== want.find_error) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("response mismatch at %0t", $realtime);
                  $display("   expected %s", fmt_rsp(want));
                  $display("   actual   %s", fmt_rsp(got));
               end
            end
         end
      end
   end

   initial begin
      chunk_req_type it;
      bit            heavy;
      int            seg;
      int            n;
      req_bus.valid <= 1'b0;
      req_bus.op <= OP_APPEND;
      req_bus.chunk_count <= '0;
      req_bus.chunk_offset <= '0;
      req_bus.chunk_kind <= '0;
      req_bus.oid_value <= '0;

      // empty table, then two full-size chunks and finds around their totals
      dir_rows.push_back(with_want(lookup('0), mk_rsp(0, 0, 0, 0, 0, 0, 0, 1)));
      dir_rows.push_back(with_want(lookup(TOTAL_MAX), mk_rsp(0, 0, 0, 0, 0, 0, 0, 1)));
      dir_rows.push_back(with_want(appnd('1, 32'd0, 3'd0),
                                   mk_rsp(1, 0, 0, 1, 48'hFFFF_FFFF, 0, 0, 0)));
      dir_rows.push_back(with_want(appnd('1, 32'd100, 3'd7),
                                   mk_rsp(2, 0, 0, 1, 48'hFFFF_FFFF, 0, 0, 0)));
      dir_rows.push_back(with_want(lookup('0), mk_rsp(2, 0, 0, 0, 0, 0, 0, 0)));
      dir_rows.push_back(with_want(lookup(40'h1_FFFF_FFFE), mk_rsp(2, 0, 0, 0, 0, 1, 100, 0)));
      dir_rows.push_back(with_want(lookup(40'h1_FFFF_FFFF), mk_rsp(2, 0, 0, 0, 0, 0, 0, 1)));
      dir_rows.push_back(with_want(lookup(TOTAL_MAX), mk_rsp(2, 0, 0, 0, 0, 0, 0, 1)));
      // fill to the end slot with zero, one and falling gaps
      dir_rows.push_back(appnd(32'd0, 32'd300, 3'd1));
      dir_rows.push_back(appnd(32'd1, 32'hFFFF_FFFF, 3'd2));
      dir_rows.push_back(appnd(32'h1234, 32'd50, 3'd3));
      dir_rows.push_back(appnd('1, 32'd150, 3'd4));
      dir_rows.push_back(appnd(32'd7, 32'd150, 3'd5));
      dir_rows.push_back(appnd(32'd0, 32'd400, 3'd6));
      dir_rows.push_back(appnd(32'd99, 32'h8000_0000, 3'd0));
      dir_rows.push_back(appnd(32'd5, 32'h8000_0010, 3'd1));
      dir_rows.push_back(appnd(32'd1, 32'h8000_0011, 3'd2));
      dir_rows.push_back(appnd(32'hFFFF, 32'h9000_0000, 3'd3));
      dir_rows.push_back(appnd(32'h1_0000, 32'hA000_0000, 3'd4));
      dir_rows.push_back(appnd(32'd2, 32'hA000_0005, 3'd5));
      dir_rows.push_back(appnd(32'd3, 32'hA000_0100, 3'd6));
      // compaction: zero gap, tie on the earliest, new entry itself, falling offset
      dir_rows.push_back(appnd(32'd10, 32'hA000_0101, 3'd7));
      dir_rows.push_back(appnd(32'd11, 32'hA000_0102, 3'd0));
      dir_rows.push_back(appnd(32'd12, 32'hA000_0102, 3'd1));
      dir_rows.push_back(appnd(32'd0, 32'd0, 3'd3));
      dir_rows.push_back(lookup(40'h0_8000_0000));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[r]) send_req(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].want);

      for (seg = 0; seg < 6; seg++) begin
         case (seg % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 85; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 85; end
            default: begin send_idle_pct = 24; stall_pct = 24; end
         endcase
         // one segment of near-max counts drives the totals into saturation
         heavy = (seg == 1);
         for (n = 0; n < 175; n++) begin
            it.op = ($urandom_range(99) < 55) ? OP_APPEND : OP_FIND;
            it.count = rand_count(heavy);
            it.offset = rand_offset();
            it.kind = kind_type'($urandom);
            it.oid = (it.op == OP_FIND) ? rand_oid() : total_type'({$urandom, $urandom});
            send_req(it, 1'b0, '0);
         end
      end
      req_bus.valid <= 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (2 * SLOTS) @(posedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
